@@ rtl/jxpl_pkg.sv @@
// jxpl_pkg: shared types, constants and byte classification for the
// exif preview locator. No dependencies; imported by the front and back.
package jxpl_pkg;

  // byte values the marker walk looks for
  localparam logic [7:0] BYTE_FF  = 8'hFF;
  localparam logic [7:0] BYTE_SOI = 8'hD8;
  localparam logic [7:0] BYTE_EOI = 8'hD9;
  localparam logic [7:0] BYTE_TEM = 8'h01;
  localparam logic [7:0] BYTE_RST0 = 8'hD0;
  localparam logic [7:0] BYTE_RST7 = 8'hD7;
  localparam logic [7:0] BYTE_SOS = 8'hDA;
  localparam logic [7:0] BYTE_APP1 = 8'hE1;

  // "Exif\0\0" signature at the start of an app1 payload
  localparam int unsigned SIG_LEN = 6;
  localparam logic [7:0] EXIF_SIG [SIG_LEN] = '{8'h45, 8'h78, 8'h69, 8'h66, 8'h00, 8'h00};
  localparam logic [2:0] SIG_LAST_IDX = 3'(SIG_LEN - 1);

  // walk phase codes
  localparam logic [3:0] PH_SOI0 = 4'd0;
  localparam logic [3:0] PH_SOI1 = 4'd1;
  localparam logic [3:0] PH_SCAN = 4'd2;
  localparam logic [3:0] PH_MARK = 4'd3;
  localparam logic [3:0] PH_LENH = 4'd4;
  localparam logic [3:0] PH_LENL = 4'd5;
  localparam logic [3:0] PH_SKIP = 4'd6;
  localparam logic [3:0] PH_SIG  = 4'd7;
  localparam logic [3:0] PH_SEEK = 4'd8;
  localparam logic [3:0] PH_TAIL = 4'd9;

  // outcome of one walk step
  localparam logic [1:0] RES_GO   = 2'd0;
  localparam logic [1:0] RES_NONE = 2'd1;
  localparam logic [1:0] RES_HIT  = 2'd2;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic is_ff;
    logic is_soi;
    logic is_eoi;
    logic is_lone;
    logic is_sos;
    logic is_app1;
  } jxpl_cls_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    jxpl_cls_t  cls;
  } jxpl_item_t;

  function automatic jxpl_cls_t jxpl_classify(input logic [7:0] b);
    jxpl_cls_t c;
    c.is_ff   = (b == BYTE_FF);
    c.is_soi  = (b == BYTE_SOI);
    c.is_eoi  = (b == BYTE_EOI);
    c.is_lone = (b == BYTE_SOI) || (b == BYTE_EOI) || (b == BYTE_TEM) ||
                ((b >= BYTE_RST0) && (b <= BYTE_RST7));
    c.is_sos  = (b == BYTE_SOS);
    c.is_app1 = (b == BYTE_APP1);
    return c;
  endfunction

endpackage

@@ rtl/jxpl_channels.sv @@
// jxpl_in_if / jxpl_out_if: valid/ready channels for head bytes and results.
// No dependencies.
interface jxpl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface jxpl_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [19:0] preview_offset;
  logic [15:0] preview_length;

  modport source (output valid, output found, output preview_offset,
                  output preview_length, input ready);
  modport sink (input valid, input found, input preview_offset,
                input preview_length, output ready);
endinterface

@@ rtl/jxpl_front.sv @@
// jxpl_front: accepts head bytes, classifies them and queues them for the back.
// Depends on jxpl_pkg and jxpl_in_if.
module jxpl_front (
  input  logic                 clk,
  input  logic                 rst_n,
  jxpl_in_if.sink              in_chan,
  output logic                 q_valid,
  output jxpl_pkg::jxpl_item_t q_item,
  input  logic                 q_pop
);
  import jxpl_pkg::*;

  jxpl_item_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]     cnt_r, cnt_nxt;
  logic                push;
  jxpl_item_t          new_item;

  // classify on the way in
  always_comb begin
    new_item.data_byte = in_chan.data_byte;
    new_item.last_byte = in_chan.last_byte;
    new_item.cls       = jxpl_classify(in_chan.data_byte);
  end

  assign in_chan.ready = (cnt_r != (QPTR_W+1)'(QUEUE_DEPTH));
  assign push          = in_chan.valid && in_chan.ready;
  assign q_valid       = (cnt_r != '0);
  assign q_item        = mem_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

@@ rtl/jxpl_back.sv @@
// jxpl_back: marker walk, exif signature check, preview search and result register.
// Depends on jxpl_pkg and jxpl_out_if; fed from jxpl_front's queue.
module jxpl_back #(
  parameter int unsigned HEAD_BYTES_MAX = 1048576
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  jxpl_pkg::jxpl_item_t q_item,
  output logic                 q_pop,
  jxpl_out_if.source           out_chan
);
  import jxpl_pkg::*;

  localparam int unsigned POS_W = $clog2(HEAD_BYTES_MAX + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(HEAD_BYTES_MAX);

  logic [3:0]       phase_r, phase_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      seg_r, seg_nxt;
  logic             app1_r, app1_nxt;
  logic [7:0]       len_hi_r, len_hi_nxt;
  logic [2:0]       sig_cnt_r, sig_cnt_nxt;
  logic [7:0]       held_r [SIG_LEN];
  logic [POS_W-1:0] start_r, start_nxt;
  logic [1:0]       prog_r, prog_nxt;
  logic             decided_r, decided_nxt;
  logic             replay_r, replay_nxt;
  logic [2:0]       rp_idx_r, rp_idx_nxt;
  logic             rp_last_r, rp_last_nxt;

  logic             out_valid_r;
  logic             found_r;
  logic [19:0]      off_r;
  logic [15:0]      len_r;

  logic [7:0]       cur_byte;
  jxpl_cls_t        cur_cls;
  logic             cur_last;
  logic             over;
  logic             active;
  logic [15:0]      seg_len;
  logic             sig_match;
  logic [1:0]       res;
  logic             start_rp;
  logic             held_we;
  logic [15:0]      hit_len;
  logic             finish;
  logic             dec_after;
  logic             emit;
  logic             can_emit;
  logic             advance;

  // current byte: queue head, or a held signature byte being replayed
  always_comb begin
    cur_byte = replay_r ? held_r[rp_idx_r] : q_item.data_byte;
    cur_cls  = replay_r ? jxpl_classify(cur_byte) : q_item.cls;
    cur_last = replay_r ? rp_last_r : q_item.last_byte;
  end

  assign over    = (pos_r == POS_MAX);
  assign active  = replay_r || q_valid;
  assign seg_len = {len_hi_r, cur_byte};
  assign hit_len = 16'(pos_r - start_r + POS_W'(1));

  // signature compare against the five held bytes and the current one
  always_comb begin
    sig_match = (cur_byte == EXIF_SIG[SIG_LEN-1]);
    for (int i = 0; i < SIG_LEN - 1; i++) begin
      sig_match = sig_match && (held_r[i] == EXIF_SIG[i]);
    end
  end

  // one walk step
  always_comb begin
    phase_nxt   = phase_r;
    seg_nxt     = seg_r;
    app1_nxt    = app1_r;
    len_hi_nxt  = len_hi_r;
    sig_cnt_nxt = sig_cnt_r;
    start_nxt   = start_r;
    prog_nxt    = prog_r;
    res         = RES_GO;
    start_rp    = 1'b0;
    held_we     = 1'b0;
    if (!replay_r && decided_r) begin
      res = RES_GO;
    end else if (!replay_r && over) begin
      res = RES_NONE;
    end else begin
      unique case (phase_r)
        PH_SOI0: begin
          if (!cur_cls.is_ff) res = RES_NONE;
          else phase_nxt = PH_SOI1;
        end
        PH_SOI1: begin
          if (!cur_cls.is_soi) res = RES_NONE;
          else phase_nxt = PH_SCAN;
        end
        PH_SCAN: begin
          if (cur_cls.is_ff) phase_nxt = PH_MARK;
        end
        PH_MARK: begin
          if (cur_cls.is_lone) begin
            phase_nxt = PH_SCAN;
          end else if (cur_cls.is_sos) begin
            res = RES_NONE;
          end else begin
            app1_nxt  = cur_cls.is_app1;
            phase_nxt = PH_LENH;
          end
        end
        PH_LENH: begin
          len_hi_nxt = cur_byte;
          phase_nxt  = PH_LENL;
        end
        PH_LENL: begin
          if (seg_len < 16'd2) begin
            res = RES_NONE;
          end else begin
            seg_nxt = seg_len - 16'd2;
            if (app1_r) begin
              sig_cnt_nxt = '0;
              phase_nxt   = PH_SIG;
            end else begin
              phase_nxt = (seg_len == 16'd2) ? PH_SCAN : PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          if (seg_r != '0) seg_nxt = seg_r - 16'd1;
          if (seg_nxt == '0) phase_nxt = PH_SCAN;
        end
        PH_SIG: begin
          held_we = 1'b1;
          if (sig_cnt_r != SIG_LAST_IDX) begin
            sig_cnt_nxt = sig_cnt_r + 3'd1;
          end else begin
            sig_cnt_nxt = '0;
            if (sig_match) begin
              if (seg_r <= 16'(SIG_LEN)) begin
                res = RES_NONE;
              end else begin
                seg_nxt   = seg_r - 16'(SIG_LEN);
                prog_nxt  = 2'd0;
                phase_nxt = PH_SEEK;
              end
            end else if (seg_r >= 16'(SIG_LEN)) begin
              seg_nxt   = seg_r - 16'(SIG_LEN);
              phase_nxt = (seg_r == 16'(SIG_LEN)) ? PH_SCAN : PH_SKIP;
            end else begin
              // segment ended inside the signature: walk on from the held bytes
              phase_nxt = PH_SCAN;
              start_rp  = 1'b1;
            end
          end
        end
        PH_SEEK: begin
          seg_nxt = seg_r - 16'd1;
          if (prog_r == 2'd2 && cur_cls.is_ff) begin
            start_nxt = pos_r - POS_W'(2);
            prog_nxt  = 2'd1;
            phase_nxt = PH_TAIL;
          end else if (cur_cls.is_ff) begin
            prog_nxt = 2'd1;
          end else if (prog_r == 2'd1 && cur_cls.is_soi) begin
            prog_nxt = 2'd2;
          end else begin
            prog_nxt = 2'd0;
          end
          if (seg_nxt == '0) res = RES_NONE;
        end
        PH_TAIL: begin
          seg_nxt = seg_r - 16'd1;
          if (prog_r == 2'd1 && cur_cls.is_eoi) begin
            res = RES_HIT;
          end else begin
            prog_nxt = cur_cls.is_ff ? 2'd1 : 2'd0;
            if (seg_nxt == '0) res = RES_NONE;
          end
        end
        default: res = RES_NONE;
      endcase
    end
  end

  // item completion and result handoff
  always_comb begin
    finish    = replay_r ? ((res != RES_GO) || (rp_idx_r == SIG_LAST_IDX)) : !start_rp;
    dec_after = decided_r || (res != RES_GO);
    emit      = active && finish && ((res != RES_GO) || (cur_last && !dec_after));
    can_emit  = !out_valid_r || out_chan.ready;
    advance   = active && (!emit || can_emit);
    q_pop     = !replay_r && q_valid && advance;
  end

  // control bookkeeping around the walk
  always_comb begin
    decided_nxt = dec_after;
    replay_nxt  = replay_r;
    rp_idx_nxt  = rp_idx_r;
    rp_last_nxt = rp_last_r;
    pos_nxt     = pos_r;
    if (replay_r) begin
      replay_nxt = !finish;
      rp_idx_nxt = rp_idx_r + 3'd1;
    end else begin
      pos_nxt = over ? pos_r : pos_r + POS_W'(1);
      if (start_rp) begin
        replay_nxt  = 1'b1;
        rp_idx_nxt  = seg_r[2:0];
        rp_last_nxt = q_item.last_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_SOI0;
      pos_r     <= '0;
      seg_r     <= '0;
      app1_r    <= 1'b0;
      len_hi_r  <= '0;
      sig_cnt_r <= '0;
      start_r   <= '0;
      prog_r    <= '0;
      decided_r <= 1'b0;
      replay_r  <= 1'b0;
      rp_idx_r  <= '0;
      rp_last_r <= 1'b0;
    end else if (advance) begin
      if (finish && cur_last) begin
        // head done: rearm for the next one
        phase_r   <= PH_SOI0;
        pos_r     <= '0;
        seg_r     <= '0;
        app1_r    <= 1'b0;
        len_hi_r  <= '0;
        sig_cnt_r <= '0;
        start_r   <= '0;
        prog_r    <= '0;
        decided_r <= 1'b0;
        replay_r  <= 1'b0;
        rp_idx_r  <= '0;
        rp_last_r <= 1'b0;
      end else begin
        phase_r   <= phase_nxt;
        pos_r     <= pos_nxt;
        seg_r     <= seg_nxt;
        app1_r    <= app1_nxt;
        len_hi_r  <= len_hi_nxt;
        sig_cnt_r <= sig_cnt_nxt;
        start_r   <= start_nxt;
        prog_r    <= prog_nxt;
        decided_r <= decided_nxt;
        replay_r  <= replay_nxt;
        rp_idx_r  <= rp_idx_nxt;
        rp_last_r <= rp_last_nxt;
      end
    end
  end

  // held signature bytes
  always_ff @(posedge clk) begin
    if (advance && held_we) begin
      held_r[sig_cnt_r] <= cur_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit && advance) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && advance) begin
      found_r <= (res == RES_HIT);
      off_r   <= (res == RES_HIT) ? 20'(start_r) : '0;
      len_r   <= (res == RES_HIT) ? hit_len : '0;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.found          = found_r;
  assign out_chan.preview_offset = off_r;
  assign out_chan.preview_length = len_r;

  // replay only runs through header phases, never the preview search
  a_replay_phase: assert property (@(posedge clk) disable iff (!rst_n)
    replay_r |-> (phase_r != PH_SEEK && phase_r != PH_TAIL))
    else $error("replay reached preview search");

  // no queue transfer while held bytes are being replayed
  a_replay_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    replay_r |-> !q_pop)
    else $error("queue popped during replay");

  // a found preview spans at least FF D8 FF D9
  a_found_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && found_r) |-> (len_r >= 16'd4))
    else $error("preview length too short");

  // not-found results carry zero offset and length
  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !found_r) |-> (off_r == '0 && len_r == '0))
    else $error("not-found result with nonzero payload");

  // a new result is loaded only when the previous one has been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |-> !(emit && advance))
    else $error("result overwritten before transfer");

endmodule

@@ rtl/jpeg_exif_preview_locator_unit.sv @@
// Exif preview locator: takes the head of a JPEG file one byte per transfer
// (last_byte on the final byte) and returns exactly one result per head: found
// with the embedded preview's FF D8 offset and length through FF D9, or found=0.
// Throughput is one byte per cycle while the result register is free to load; the
// back end also stalls the byte stream when an APP1 segment ends inside its six
// signature bytes and the walk resumes over the held bytes. A byte transfer
// reaches its result via the four-entry byte queue and then the result register.
// HEAD_BYTES_MAX bounds the bytes walked per head; later bytes give found=0.
// Depends on jxpl_pkg, jxpl_channels, jxpl_front and jxpl_back.
module jpeg_exif_preview_locator_unit #(
  parameter int unsigned HEAD_BYTES_MAX = 1048576
) (
  input  logic        clk,
  input  logic        rst_n,
  jxpl_in_if.sink     in_chan,
  jxpl_out_if.source  out_chan
);
  import jxpl_pkg::*;

  logic       q_valid;
  jxpl_item_t q_item;
  logic       q_pop;

  // byte classification and queue
  jxpl_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  // marker walk and preview search
  jxpl_back #(
    .HEAD_BYTES_MAX (HEAD_BYTES_MAX)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

@@ sim/testbench.sv @@
// testbench: drives jpeg heads into the exif preview locator and checks every
// result against an untimed predictor of the marker walk.
// Depends on jxpl_pkg, jxpl_channels and jpeg_exif_preview_locator_unit.
`timescale 1ns / 100ps

module testbench;
  import jxpl_pkg::*;

  // head limit; the heads sent here stay below it
  localparam int unsigned HEAD_MAX = 4096;
  localparam int unsigned MAX_SHOWN = 10;
  localparam int unsigned HOLD_CYCLES = 300;

  // marker codes used for ordinary skipped segments
  localparam logic [7:0] MRK_SOF0 = 8'hC0;
  localparam logic [7:0] MRK_DHT  = 8'hC4;
  localparam logic [7:0] MRK_APP0 = 8'hE0;

  typedef struct packed {
    logic        found;
    logic [19:0] offset;
    logic [15:0] length;
  } preview_t;

  logic clk;
  logic rst_n;

  jxpl_in_if  in_chan ();
  jxpl_out_if out_chan ();

  jpeg_exif_preview_locator_unit #(.HEAD_BYTES_MAX(HEAD_MAX)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  // predicted walk state
  logic [3:0]  walk_ph;
  int unsigned head_pos;
  logic [15:0] seg_left;
  logic [7:0]  seg_marker;
  logic [7:0]  len_msb;
  int unsigned sig_idx;
  logic [7:0]  sig_hold [SIG_LEN];
  int unsigned pv_first;
  logic [1:0]  soi_match;
  bit          head_settled;
  bit          replay_pending;
  int unsigned replay_from;

  preview_t    preview_q [$];
  logic [7:0]  head_buf [$];
  int unsigned mismatch_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req_cnt = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // overall time limit
  initial begin
    #1ms;
    $display("Verification failed");
    $finish;
  end

  function automatic bit is_standalone(input logic [7:0] m);
    return m == BYTE_SOI || m == BYTE_EOI || m == BYTE_TEM ||
           (m >= BYTE_RST0 && m <= BYTE_RST7);
  endfunction

  function automatic void clear_walk();
    walk_ph        = PH_SOI0;
    head_pos       = 0;
    seg_left       = '0;
    seg_marker     = '0;
    len_msb        = '0;
    sig_idx        = 0;
    pv_first       = 0;
    soi_match      = '0;
    head_settled   = 1'b0;
    replay_pending = 1'b0;
    replay_from    = 0;
    for (int i = 0; i < SIG_LEN; i++) sig_hold[i] = '0;
  endfunction

  // one byte through the marker walk; a short app1 only flags its replay
  function automatic logic [1:0] walk_byte(input logic [7:0] b, input int unsigned pos,
                                           output int unsigned hit_len);
    bit sig_ok;
    hit_len = 0;
    case (walk_ph)
      PH_SOI0: begin
        if (b != BYTE_FF) return RES_NONE;
        walk_ph = PH_SOI1;
      end
      PH_SOI1: begin
        if (b != BYTE_SOI) return RES_NONE;
        walk_ph = PH_SCAN;
      end
      PH_SCAN: begin
        if (b == BYTE_FF) walk_ph = PH_MARK;
      end
      PH_MARK: begin
        if (is_standalone(b)) begin
          walk_ph = PH_SCAN;
        end else if (b == BYTE_SOS) begin
          return RES_NONE;
        end else begin
          seg_marker = b;
          walk_ph = PH_LENH;
        end
      end
      PH_LENH: begin
        len_msb = b;
        walk_ph = PH_LENL;
      end
      PH_LENL: begin
        if ({len_msb, b} < 16'd2) return RES_NONE;
        seg_left = {len_msb, b} - 16'd2;
        if (seg_marker == BYTE_APP1) begin
          sig_idx = 0;
          walk_ph = PH_SIG;
        end else begin
          walk_ph = (seg_left != 0) ? PH_SKIP : PH_SCAN;
        end
      end
      PH_SKIP: begin
        if (seg_left != 0) seg_left--;
        if (seg_left == 0) walk_ph = PH_SCAN;
      end
      PH_SIG: begin
        if (sig_idx < SIG_LEN) sig_hold[sig_idx] = b;
        sig_idx++;
        if (sig_idx < SIG_LEN) return RES_GO;
        sig_idx = 0;
        sig_ok = 1'b1;
        for (int i = 0; i < SIG_LEN; i++) if (sig_hold[i] != EXIF_SIG[i]) sig_ok = 1'b0;
        if (sig_ok) begin
          if (seg_left <= 16'd6) return RES_NONE;
          seg_left -= 16'd6;
          soi_match = 2'd0;
          walk_ph = PH_SEEK;
        end else if (seg_left >= 16'd6) begin
          seg_left -= 16'd6;
          walk_ph = (seg_left != 0) ? PH_SKIP : PH_SCAN;
        end else begin
          // segment ended inside the signature: walk resumes over the held bytes
          walk_ph = PH_SCAN;
          replay_pending = 1'b1;
          replay_from = seg_left;
        end
      end
      PH_SEEK: begin
        seg_left--;
        if (soi_match == 2'd2 && b == BYTE_FF) begin
          pv_first = pos - 2;
          soi_match = 2'd1;
          walk_ph = PH_TAIL;
        end else if (b == BYTE_FF) begin
          soi_match = 2'd1;
        end else if (soi_match == 2'd1 && b == BYTE_SOI) begin
          soi_match = 2'd2;
        end else begin
          soi_match = 2'd0;
        end
        if (seg_left == 0) return RES_NONE;
      end
      PH_TAIL: begin
        seg_left--;
        if (soi_match == 2'd1 && b == BYTE_EOI) begin
          hit_len = pos - pv_first + 1;
          return RES_HIT;
        end
        soi_match = (b == BYTE_FF) ? 2'd1 : 2'd0;
        if (seg_left == 0) return RES_NONE;
      end
      default: return RES_NONE;
    endcase
    return RES_GO;
  endfunction

  // expected result of one accepted byte
  function automatic void predict_byte(input logic [7:0] b, input bit last);
    logic [7:0]  saved [SIG_LEN];
    logic [1:0]  res;
    int unsigned hit_len;
    preview_t    expected;
    res = RES_GO;
    hit_len = 0;
    if (!head_settled) begin
      if (head_pos >= HEAD_MAX) begin
        res = RES_NONE;
      end else begin
        res = walk_byte(b, head_pos, hit_len);
        // a replay never reaches a full signature, so it cannot nest
        if (res == RES_GO && replay_pending) begin
          replay_pending = 1'b0;
          saved = sig_hold;
          for (int i = replay_from; i < SIG_LEN && res == RES_GO; i++)
            res = walk_byte(saved[i], head_pos - 5 + i, hit_len);
        end
      end
      if (res != RES_GO) head_settled = 1'b1;
    end
    if (head_pos < HEAD_MAX) head_pos++;
    if (res == RES_HIT) begin
      expected.found  = 1'b1;
      expected.offset = pv_first[19:0];
      expected.length = hit_len[15:0];
      preview_q.push_back(expected);
    end else if (res == RES_NONE || (last && !head_settled)) begin
      expected = '0;
      preview_q.push_back(expected);
    end
    if (last) clear_walk();
  endfunction

  // byte transfer with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input bit last);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.data_byte <= b;
    in_chan.last_byte <= last;
    do begin
      @(negedge clk);
      taken = in_chan.ready;
      @(posedge clk);
    end while (!taken);
    predict_byte(b, last);
  endtask

  task automatic send_head();
    int unsigned count;
    count = head_buf.size();
    for (int unsigned i = 0; i < count; i++) send_byte(head_buf[i], i == count - 1);
    head_buf.delete();
  endtask

  // head building helpers
  function automatic void put(input logic [7:0] b);
    head_buf.push_back(b);
  endfunction

  function automatic logic [7:0] rand_non_ff();
    return 8'($urandom_range(254));
  endfunction

  function automatic void put_fill(input int unsigned n);
    repeat (n) put(rand_non_ff());
  endfunction

  function automatic void put_seg_head(input logic [7:0] marker, input logic [15:0] len);
    put(BYTE_FF);
    put(marker);
    put(len[15:8]);
    put(len[7:0]);
  endfunction

  function automatic void put_exif_sig();
    for (int i = 0; i < SIG_LEN; i++) put(EXIF_SIG[i]);
  endfunction

  // payload bytes leaning toward the preview delimiters
  function automatic logic [7:0] rand_payload_byte();
    case ($urandom_range(9))
      0, 1, 2: return BYTE_FF;
      3:       return BYTE_SOI;
      4:       return BYTE_EOI;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] rand_standalone();
    case ($urandom_range(3))
      0:       return BYTE_TEM;
      1:       return BYTE_SOI;
      2:       return BYTE_EOI;
      default: return BYTE_RST0 + 8'($urandom_range(7));
    endcase
  endfunction

  function automatic logic [7:0] rand_seg_marker();
    logic [7:0] m;
    do m = 8'($urandom);
    while (is_standalone(m) || m == BYTE_SOS || m == BYTE_APP1);
    return m;
  endfunction

  // mostly well-formed heads with random content, some noise and truncation
  function automatic void put_random_head();
    int unsigned n, plen, at, keep;
    logic [7:0]  pay [$];
    if ($urandom_range(99) < 12) begin
      if ($urandom_range(1) == 1) begin
        put(BYTE_FF);
        put(BYTE_SOI);
      end
      repeat ($urandom_range(8, 1)) put(8'($urandom));
      return;
    end
    put(BYTE_FF);
    put(($urandom_range(19) == 0) ? 8'($urandom) : BYTE_SOI);
    // leading fill, standalone markers and skipped segments
    repeat ($urandom_range(3)) begin
      case ($urandom_range(9))
        0, 1: put_fill($urandom_range(3, 1));
        2, 3: begin
          put(BYTE_FF);
          put(rand_standalone());
        end
        4: begin
          put(BYTE_FF);
          put(BYTE_SOS);
        end
        default: begin
          if ($urandom_range(15) == 0) begin
            put_seg_head(rand_seg_marker(), 16'($urandom_range(1)));
          end else begin
            n = $urandom_range(8);
            put_seg_head(rand_seg_marker(), 16'(n + 2));
            repeat (n) put(8'($urandom));
          end
        end
      endcase
    end
    if ($urandom_range(99) < 85) begin
      if ($urandom_range(99) < 80) begin
        // exif app1 with an optional embedded preview
        n = $urandom_range(24, 1);
        put_seg_head(BYTE_APP1, 16'(n + 8));
        put_exif_sig();
        if ($urandom_range(9) == 0)
          head_buf[head_buf.size() - 1 - $urandom_range(5)] = 8'($urandom);
        repeat (n) pay.push_back(rand_payload_byte());
        if ($urandom_range(99) < 70) begin
          at = $urandom_range(n - 1);
          plen = $urandom_range(12);
          for (int unsigned k = 0; k < plen + 5 && at + k < n; k++) begin
            if (k == 0 || k == 2 || k == plen + 3) pay[at + k] = BYTE_FF;
            else if (k == 1) pay[at + k] = BYTE_SOI;
            else if (k == plen + 4) pay[at + k] = BYTE_EOI;
          end
        end
        foreach (pay[i]) put(pay[i]);
      end else begin
        // app1 whose length ends inside or at the end of the signature bytes
        n = $urandom_range(6);
        put_seg_head(BYTE_APP1, 16'(n + 2));
        if ($urandom_range(2) == 0) begin
          put_exif_sig();
        end else begin
          for (int unsigned i = 0; i < SIG_LEN; i++)
            put((i == n) ? BYTE_FF : rand_payload_byte());
        end
      end
    end
    repeat ($urandom_range(4)) put(rand_payload_byte());
    if ($urandom_range(99) < 15) begin
      keep = $urandom_range(head_buf.size(), 1);
      while (head_buf.size() > keep) void'(head_buf.pop_back());
    end
  endfunction

  // directed tests
  task automatic test_bad_start();
    put(8'h5A);
    send_head();
    put(BYTE_FF);
    send_head();
    put(BYTE_FF); put(8'h00); put(BYTE_FF); put(BYTE_SOI);
    send_head();
    // opens correctly but ends undecided
    put(BYTE_FF); put(BYTE_SOI);
    send_head();
  endtask

  task automatic test_marker_walk();
    put(BYTE_FF); put(BYTE_SOI);
    put_fill(2);
    put(BYTE_FF); put(BYTE_RST0);
    put(BYTE_FF); put(BYTE_RST7);
    put(BYTE_FF); put(BYTE_TEM);
    put(BYTE_FF); put(BYTE_EOI);
    put(BYTE_FF); put(BYTE_SOI);
    put_seg_head(MRK_APP0, 16'd6);
    put_fill(4);
    // ff after ff is a marker code with a length
    put_seg_head(BYTE_FF, 16'd3);
    put(8'hA5);
    put_seg_head(MRK_SOF0, 16'd2);
    put_seg_head(BYTE_APP1, 16'd32);
    put_exif_sig();
    put(8'h11); put(BYTE_FF); put(BYTE_SOI); put(BYTE_FF);
    put(8'h22); put(BYTE_FF); put(BYTE_FF); put(BYTE_EOI);
    put_fill(2);
    put(8'h00); put(BYTE_FF);
    send_head();
  endtask

  task automatic test_walk_stops();
    put(BYTE_FF); put(BYTE_SOI); put(BYTE_FF); put(BYTE_SOS); put(8'h00); put(8'h08);
    send_head();
    put(BYTE_FF); put(BYTE_SOI); put_seg_head(MRK_DHT, 16'd1); put(8'h00);
    send_head();
    put(BYTE_FF); put(BYTE_SOI); put_seg_head(BYTE_APP1, 16'd0);
    send_head();
  endtask

  task automatic test_short_app1();
    // signature bytes hold the start of the next app1
    put(BYTE_FF); put(BYTE_SOI);
    put_seg_head(BYTE_APP1, 16'd4);
    put(8'hAA); put(8'hBB); put(BYTE_FF); put(BYTE_APP1); put(8'h00); put(8'h14);
    put_exif_sig();
    put(BYTE_FF); put(BYTE_SOI); put(BYTE_FF); put(8'h33); put(BYTE_FF); put(BYTE_EOI);
    put_fill(6);
    put(8'h00);
    send_head();
    // signature matches but nothing follows it
    put(BYTE_FF); put(BYTE_SOI);
    put_seg_head(BYTE_APP1, 16'd8);
    put_exif_sig();
    put_fill(2);
    send_head();
    // empty app1: the held bytes are walked again from the first, sos inside them
    put(BYTE_FF); put(BYTE_SOI);
    put_seg_head(BYTE_APP1, 16'd2);
    put(BYTE_FF); put(BYTE_SOS); put_fill(4);
    send_head();
    // near-miss signature, only its final ff is walked again
    put(BYTE_FF); put(BYTE_SOI);
    put_seg_head(BYTE_APP1, 16'd7);
    for (int i = 0; i < SIG_LEN - 1; i++) put(EXIF_SIG[i]);
    put(BYTE_FF);
    put(BYTE_EOI);
    send_head();
  endtask

  task automatic test_cut_off();
    // region ends while waiting for the closing marker
    put(BYTE_FF); put(BYTE_SOI);
    put_seg_head(BYTE_APP1, 16'd16);
    put_exif_sig();
    put(BYTE_FF); put(BYTE_SOI); put(BYTE_FF); put_fill(3); put(BYTE_FF); put(8'h00);
    put_fill(3);
    send_head();
    // region ends before any preview start
    put(BYTE_FF); put(BYTE_SOI);
    put_seg_head(BYTE_APP1, 16'd11);
    put_exif_sig();
    put(BYTE_FF); put(BYTE_SOI); put(BYTE_EOI);
    send_head();
    // head ends inside the preview
    put(BYTE_FF); put(BYTE_SOI);
    put_seg_head(BYTE_APP1, 16'd64);
    put_exif_sig();
    put(BYTE_FF); put(BYTE_SOI); put(BYTE_FF); put(8'h12); put(BYTE_FF);
    send_head();
  endtask

  task automatic test_later_app1();
    put(BYTE_FF); put(BYTE_SOI);
    put_seg_head(BYTE_APP1, 16'd10);
    put(EXIF_SIG[0]); put(EXIF_SIG[1]); put(EXIF_SIG[2]); put(8'h7A);
    put(EXIF_SIG[4]); put(EXIF_SIG[5]);
    put_fill(2);
    put_seg_head(BYTE_APP1, 16'd20);
    put_exif_sig();
    // overlapping delimiters inside the preview
    put(BYTE_FF); put(BYTE_FF); put(BYTE_SOI); put(BYTE_FF);
    put(BYTE_SOI); put(BYTE_FF); put(BYTE_FF); put(BYTE_EOI);
    put_fill(4);
    send_head();
  endtask

  // receiver holds off while one-byte heads keep coming
  task automatic test_back_pressure();
    hold_req_cnt++;
    repeat (20) begin
      put(8'($urandom));
      send_head();
    end
  endtask

  task automatic test_random_heads(input int unsigned heads);
    repeat (heads) begin
      put_random_head();
      send_head();
    end
  endtask

  // result receiver: random stalls plus requested long hold-offs
  initial begin : receiver
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_req_cnt) begin
        hold_seen = hold_req_cnt;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic void flag_mismatch(input string what, input preview_t want,
                                        input preview_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_SHOWN)
      $display("%s: expected found=%0d offset=%0d length=%0d, got found=%0d offset=%0d length=%0d",
               what, want.found, want.offset, want.length, got.found, got.offset, got.length);
  endfunction

  // result check, sampled on the falling edge ahead of the transfer edge
  always @(negedge clk) begin : result_check
    preview_t want;
    preview_t got;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got.found  = out_chan.found;
      got.offset = out_chan.preview_offset;
      got.length = out_chan.preview_length;
      if (preview_q.size() == 0) begin
        flag_mismatch("result with none pending", '0, got);
      end else begin
        want = preview_q.pop_front();
        if (got.found !== want.found || got.offset !== want.offset ||
            got.length !== want.length)
          flag_mismatch("result mismatch", want, got);
      end
    end
  end

  initial begin : stimulus
    in_chan.valid     <= 1'b0;
    in_chan.data_byte <= 8'h00;
    in_chan.last_byte <= 1'b0;
    rst_n             <= 1'b0;
    clear_walk();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, no idling
    test_bad_start();
    test_marker_walk();
    test_walk_stops();
    test_short_app1();
    test_cut_off();
    test_later_app1();
    test_back_pressure();

    // random heads under each idling mix
    test_random_heads(2);
    send_idle_pct = 68;
    recv_stall_pct = 0;
    test_random_heads(2);
    send_idle_pct = 0;
    recv_stall_pct = 68;
    test_random_heads(2);
    send_idle_pct = 19;
    recv_stall_pct = 19;
    test_random_heads(2);

    // drain
    in_chan.valid <= 1'b0;
    while (preview_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
